### sv/tpq_pkg.sv
// shared constants and types of the timeout priority queue
`default_nettype none

package tpq_pkg;

   // default sizing, handed to the top level parameters
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int HANDLE_BITS_DEF = 8;
   localparam int HANDLE_MAX_BITS = 16;

   // fixed field widths of the channels
   localparam int OPCODE_BITS  = 2;
   localparam int TIME_BITS    = 32;
   localparam int TIMEOUT_BITS = 20;
   localparam int IN_HANDLE_BITS = 8;
   localparam int KIND_BITS    = 2;

   // results of one sweep, done marker included
   localparam int MAX_RESULTS = 64;
   localparam int CLOSE_BITS  = $clog2(MAX_RESULTS);

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // request opcodes
   localparam logic [OPCODE_BITS-1:0] OP_ADD    = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_CANCEL = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_SWEEP  = 2'd2;

   // response kinds
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ADD_OK   = 2'd0,
      KIND_ADD_FULL = 2'd1,
      KIND_CLOSE    = 2'd2,
      KIND_DONE     = 2'd3
   } kind_type;

   // command broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_CANCEL,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [TIME_BITS-1:0]   expiry;
   } cell_cmd_type;

endpackage

`default_nettype wire

### sv/tpq_req_if.sv
// request channel of the timeout priority queue
`default_nettype none

interface tpq_req_if;
   import tpq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OPCODE_BITS-1:0]     opcode;
   logic [TIME_BITS-1:0]       now_ms;
   logic [TIMEOUT_BITS-1:0]    timeout_ms;
   logic [IN_HANDLE_BITS-1:0]  handle;

   modport source (output valid, opcode, now_ms, timeout_ms, handle, input ready);
   modport sink   (input valid, opcode, now_ms, timeout_ms, handle, output ready);
endinterface

`default_nettype wire

### sv/tpq_rsp_if.sv
// response channel of the timeout priority queue
`default_nettype none

interface tpq_rsp_if;
   import tpq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [KIND_BITS-1:0]       kind;
   logic [IN_HANDLE_BITS-1:0]  closed_handle;
   logic                       last;

   modport source (output valid, kind, closed_handle, last, input ready);
   modport sink   (input valid, kind, closed_handle, last, output ready);
endinterface

`default_nettype wire

### sv/timeout_priority_queue_top.sv
// top level of the timeout priority queue: sequencer and sorted cell chain
//
// Keeps connection timers sorted by expiry, earliest at cell 0, in a chain
// of QUEUE_DEPTH cells that shift right on insert and left on removal.
// req carries add, cancel and sweep transactions; rsp returns results with
// last set on the final result of each of them; unused opcodes get none.
// One request is worked on at a time. An add or cancel is accepted, then
// executed in a step in which the whole chain updates at once; its result
// enters the response register at the end of that step. A sweep drops
// entries from the front one by one, whether each is reported closed or
// was cancelled, then emits the done marker; at most 63 closes per sweep.
// A stalled receiver holds the response register, and the sequencer waits
// in place until it frees; nothing is dropped.
// Reset empties the queue at once: the fill count and deleted flags clear,
// no clearing pass is needed.
`default_nettype none

module timeout_priority_queue_top #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
   parameter int HANDLE_BITS = tpq_pkg::HANDLE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tpq_req_if.sink    req,
   tpq_rsp_if.source  rsp
);
   import tpq_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH+1);

   cell_cmd_type           cmd;
   logic [HANDLE_BITS-1:0] key_handle;
   logic [CNT_BITS-1:0]    count;

   // neighbor links, cell j sits at link j+1, ends tied to zero
   logic [TIME_BITS-1:0]   lk_expiry  [QUEUE_DEPTH+2];
   logic [HANDLE_BITS-1:0] lk_handle  [QUEUE_DEPTH+2];
   logic                   lk_deleted [QUEUE_DEPTH+2];
   logic                   lk_gt      [QUEUE_DEPTH+1];

   assign lk_expiry[0]              = '0;
   assign lk_handle[0]              = '0;
   assign lk_deleted[0]             = 1'b0;
   assign lk_gt[0]                  = 1'b0;
   assign lk_expiry[QUEUE_DEPTH+1]  = '0;
   assign lk_handle[QUEUE_DEPTH+1]  = '0;
   assign lk_deleted[QUEUE_DEPTH+1] = 1'b0;

   // sequencer
   tpq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .front_expiry  (lk_expiry[1]),
      .front_handle  (lk_handle[1]),
      .front_deleted (lk_deleted[1]),
      .cmd           (cmd),
      .key_handle    (key_handle),
      .count         (count)
   );

   // sorted cell chain
   for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
      tpq_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .HANDLE_BITS (HANDLE_BITS),
         .CELL_INDEX  (j)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .key_handle   (key_handle),
         .count        (count),
         .prev_gt      (lk_gt[j]),
         .prev_expiry  (lk_expiry[j]),
         .prev_handle  (lk_handle[j]),
         .prev_deleted (lk_deleted[j]),
         .next_expiry  (lk_expiry[j+2]),
         .next_handle  (lk_handle[j+2]),
         .next_deleted (lk_deleted[j+2]),
         .gt           (lk_gt[j+1]),
         .expiry       (lk_expiry[j+1]),
         .handle       (lk_handle[j+1]),
         .deleted      (lk_deleted[j+1])
      );
   end

endmodule

`default_nettype wire

### sv/tpq_cell.sv
// one slot of the sorted timer chain
`default_nettype none

module tpq_cell #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
   parameter int HANDLE_BITS = tpq_pkg::HANDLE_BITS_DEF,
   parameter int CELL_INDEX  = 0
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire tpq_pkg::cell_cmd_type                 cmd,
   input  wire logic [HANDLE_BITS-1:0]                key_handle,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]      count,
   input  wire logic                                  prev_gt,
   input  wire logic [tpq_pkg::TIME_BITS-1:0]         prev_expiry,
   input  wire logic [HANDLE_BITS-1:0]                prev_handle,
   input  wire logic                                  prev_deleted,
   input  wire logic [tpq_pkg::TIME_BITS-1:0]         next_expiry,
   input  wire logic [HANDLE_BITS-1:0]                next_handle,
   input  wire logic                                  next_deleted,
   output logic                                       gt,
   output logic [tpq_pkg::TIME_BITS-1:0]              expiry,
   output logic [HANDLE_BITS-1:0]                     handle,
   output logic                                       deleted
);
   import tpq_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH+1);
   localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(CELL_INDEX);

   logic [TIME_BITS-1:0]   expiry_ff, expiry_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic                   deleted_ff, deleted_in;
   logic                   occupied;
   logic                   at_tail;

   // occupancy follows from the fill count
   assign occupied = count > MY_INDEX;
   assign at_tail  = count == MY_INDEX;
   assign gt       = occupied && (expiry_ff > cmd.expiry);

   // next contents of the slot
   always_comb begin
      expiry_in  = expiry_ff;
      handle_in  = handle_ff;
      deleted_in = deleted_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_INSERT: begin
            priority if (prev_gt) begin
               expiry_in  = prev_expiry;
               handle_in  = prev_handle;
               deleted_in = prev_deleted;
            end else if (gt || at_tail) begin
               expiry_in  = cmd.expiry;
               handle_in  = key_handle;
               deleted_in = 1'b0;
            end
         end
         CELL_CANCEL: begin
            if (occupied && (handle_ff == key_handle)) begin
               deleted_in = 1'b1;
            end
         end
         CELL_POP: begin
            expiry_in  = next_expiry;
            handle_in  = next_handle;
            deleted_in = next_deleted;
         end
         default: begin
         end
      endcase
   end

   // slot payload
   always_ff @(posedge clock) begin
      expiry_ff <= expiry_in;
      handle_ff <= handle_in;
   end

   // deleted flag
   always_ff @(posedge clock) begin
      if (reset) begin
         deleted_ff <= 1'b0;
      end else begin
         deleted_ff <= deleted_in;
      end
   end

   assign expiry  = expiry_ff;
   assign handle  = handle_ff;
   assign deleted = deleted_ff;

endmodule

`default_nettype wire

### sv/tpq_ctrl.sv
// sequencer of the timeout priority queue: request capture, chain commands, response register
`default_nettype none

module tpq_ctrl #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
   parameter int HANDLE_BITS = tpq_pkg::HANDLE_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   tpq_req_if.sink                                    req,
   tpq_rsp_if.source                                  rsp,
   input  wire logic [tpq_pkg::TIME_BITS-1:0]         front_expiry,
   input  wire logic [HANDLE_BITS-1:0]                front_handle,
   input  wire logic                                  front_deleted,
   output tpq_pkg::cell_cmd_type                      cmd,
   output logic [HANDLE_BITS-1:0]                     key_handle,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]           count
);
   import tpq_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH+1);
   localparam logic [CNT_BITS-1:0]   FULL_COUNT  = CNT_BITS'(QUEUE_DEPTH);
   localparam logic [CLOSE_BITS-1:0] CLOSE_LIMIT = CLOSE_BITS'(MAX_RESULTS - 1);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type                  state_ff, state_in;
   logic [OPCODE_BITS-1:0]     op_ff;
   logic [TIME_BITS-1:0]       now_ff;
   logic [TIME_BITS-1:0]       exp_ff;
   logic [HANDLE_BITS-1:0]     hkey_ff;
   logic [CNT_BITS-1:0]        count_ff, count_in;
   logic [CLOSE_BITS-1:0]      closes_ff, closes_in;
   logic                       rsp_valid_ff;
   kind_type                   rsp_kind_ff;
   logic [IN_HANDLE_BITS-1:0]  rsp_handle_ff;
   logic                       rsp_last_ff;

   logic                       out_free;
   logic                       emit;
   kind_type                   emit_kind;
   logic [IN_HANDLE_BITS-1:0]  emit_handle;
   logic                       emit_last;
   logic                       front_occ;
   logic                       accept;
   logic [TIME_BITS:0]         sum;
   logic [TIME_BITS-1:0]       exp_calc;
   logic [HANDLE_MAX_BITS-1:0] req_handle_wide;
   logic [HANDLE_MAX_BITS-1:0] key_wide;
   logic [HANDLE_MAX_BITS-1:0] front_wide;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign front_occ = count_ff != '0;

   // expiry of an add, saturated at the top of the time range
   assign sum      = {1'b0, req.now_ms} + (TIME_BITS+1)'(req.timeout_ms);
   assign exp_calc = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];

   // handle width adaption between channel and storage
   assign req_handle_wide = HANDLE_MAX_BITS'(req.handle);
   assign key_wide        = HANDLE_MAX_BITS'(hkey_ff);
   assign front_wide      = HANDLE_MAX_BITS'(front_handle);

   // per-cycle decision while an item is at work, and start of a new one
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      closes_in   = closes_ff;
      cmd.op      = CELL_HOLD;
      cmd.expiry  = exp_ff;
      emit        = 1'b0;
      emit_kind   = KIND_DONE;
      emit_handle = key_wide[IN_HANDLE_BITS-1:0];
      emit_last   = 1'b1;
      if (state_ff == S_EXEC) begin
         unique case (op_ff)
            OP_ADD: begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (count_ff == FULL_COUNT) begin
                     emit_kind = KIND_ADD_FULL;
                  end else begin
                     emit_kind = KIND_ADD_OK;
                     cmd.op    = CELL_INSERT;
                     count_in  = count_ff + 1'b1;
                  end
               end
            end
            OP_CANCEL: begin
               if (out_free) begin
                  emit     = 1'b1;
                  cmd.op   = CELL_CANCEL;
                  state_in = S_IDLE;
               end
            end
            OP_SWEEP: begin
               priority if (front_occ && front_deleted) begin
                  // deleted entries leave silently
                  cmd.op   = CELL_POP;
                  count_in = count_ff - 1'b1;
               end else if (front_occ && (now_ff >= front_expiry)
                            && (closes_ff != CLOSE_LIMIT)) begin
                  if (out_free) begin
                     emit        = 1'b1;
                     emit_kind   = KIND_CLOSE;
                     emit_handle = front_wide[IN_HANDLE_BITS-1:0];
                     emit_last   = 1'b0;
                     cmd.op      = CELL_POP;
                     count_in    = count_ff - 1'b1;
                     closes_in   = closes_ff + 1'b1;
                  end
               end else begin
                  // front not expired, queue empty or close budget used up
                  if (out_free) begin
                     emit        = 1'b1;
                     emit_handle = '0;
                     state_in    = S_IDLE;
                  end
               end
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end else if (accept) begin
         // a new request starts with a fresh close budget
         state_in  = S_EXEC;
         closes_in = '0;
      end
   end

   // state, captured request and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         closes_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         closes_ff <= closes_in;
         if (accept) begin
            op_ff     <= req.opcode;
            now_ff    <= req.now_ms;
            exp_ff    <= exp_calc;
            hkey_ff   <= req_handle_wide[HANDLE_BITS-1:0];
         end
         if (emit) begin
            rsp_valid_ff  <= 1'b1;
            rsp_kind_ff   <= emit_kind;
            rsp_handle_ff <= emit_handle;
            rsp_last_ff   <= emit_last;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.kind          = rsp_kind_ff;
   assign rsp.closed_handle = rsp_handle_ff;
   assign rsp.last          = rsp_last_ff;
   assign key_handle        = hkey_ff;
   assign count             = count_ff;

endmodule

`default_nettype wire

### verif/tpq_checker.sv
// checker of the timeout priority queue: predicts results and compares them
`timescale 1ns / 100ps

module tpq_checker #(
   parameter int QUEUE_DEPTH = tpq_pkg::QUEUE_DEPTH_DEF,
   parameter int HANDLE_BITS = tpq_pkg::HANDLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   tpq_req_if   req_mon,
   tpq_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   results_outstanding
);
   import tpq_pkg::*;

   // one stored timer of the predicted queue
   typedef struct {
      logic [TIME_BITS-1:0]      expiry;
      logic [IN_HANDLE_BITS-1:0] handle;
      bit                        deleted;
   } timer_entry_type;

   // one predicted response transaction
   typedef struct {
      kind_type                  kind;
      logic [IN_HANDLE_BITS-1:0] handle;
      logic                      last;
   } timer_result_type;

   timer_entry_type  timers[$];
   timer_result_type expected_results[$];
   int               error_total = 0;

   assign mismatch_count      = error_total;
   assign results_outstanding = expected_results.size();

   function automatic void push_result(kind_type kind, logic [IN_HANDLE_BITS-1:0] handle,
                                       logic last);
      timer_result_type res;
      res.kind   = kind;
      res.handle = handle;
      res.last   = last;
      expected_results.push_back(res);
   endfunction

   // predicted effect of one request transaction on the timer queue
   function automatic void apply_timer_request(logic [OPCODE_BITS-1:0] opcode,
                                               logic [TIME_BITS-1:0] now_ms,
                                               logic [TIMEOUT_BITS-1:0] timeout_ms,
                                               logic [IN_HANDLE_BITS-1:0] handle_in);
      int                        hmask;
      logic [IN_HANDLE_BITS-1:0] handle;
      logic [TIME_BITS:0]        sum;
      logic [TIME_BITS-1:0]      expiry;
      int                        pos;
      int                        closes;
      timer_entry_type           fresh;
      hmask  = (1 << HANDLE_BITS) - 1;
      handle = handle_in & hmask[IN_HANDLE_BITS-1:0];
      case (opcode)
         OP_ADD: begin
            if (timers.size() >= QUEUE_DEPTH) begin
               push_result(KIND_ADD_FULL, handle, 1'b1);
            end else begin
               // expiry saturates at the top of the time range
               sum    = {1'b0, now_ms} + {{(TIME_BITS-TIMEOUT_BITS+1){1'b0}}, timeout_ms};
               expiry = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
               // equal expiry goes behind the entries already there
               pos = timers.size();
               while (pos > 0 && timers[pos-1].expiry > expiry) pos--;
               fresh.expiry  = expiry;
               fresh.handle  = handle;
               fresh.deleted = 1'b0;
               timers.insert(pos, fresh);
               push_result(KIND_ADD_OK, handle, 1'b1);
            end
         end
         OP_CANCEL: begin
            foreach (timers[i]) begin
               if (timers[i].handle == handle) timers[i].deleted = 1'b1;
            end
            push_result(KIND_DONE, handle, 1'b1);
         end
         OP_SWEEP: begin
            closes = 0;
            while (timers.size() > 0) begin
               if (timers[0].deleted) begin
                  void'(timers.pop_front());
               end else if (now_ms >= timers[0].expiry) begin
                  // room is kept for the done marker
                  if (closes >= MAX_RESULTS - 1) break;
                  push_result(KIND_CLOSE, timers[0].handle, 1'b0);
                  closes++;
                  void'(timers.pop_front());
               end else begin
                  break;
               end
            end
            push_result(KIND_DONE, '0, 1'b1);
         end
         default: begin
            // unused opcode: no effect, no response
         end
      endcase
   endfunction

   // compare each response transaction, then predict each request transaction
   always @(posedge clock) begin
      if (reset) begin
         timers.delete();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response kind %0d handle %0h last %0b", $time,
                        rsp_mon.kind, rsp_mon.closed_handle, rsp_mon.last);
               error_total++;
            end else begin
               if (rsp_mon.kind !== expected_results[0].kind) begin
                  $display("%0t: kind mismatch expected %0d actual %0d", $time,
                           expected_results[0].kind, rsp_mon.kind);
                  error_total++;
               end
               if (rsp_mon.closed_handle !== expected_results[0].handle) begin
                  $display("%0t: handle mismatch expected %0h actual %0h", $time,
                           expected_results[0].handle, rsp_mon.closed_handle);
                  error_total++;
               end
               if (rsp_mon.last !== expected_results[0].last) begin
                  $display("%0t: last mismatch expected %0b actual %0b", $time,
                           expected_results[0].last, rsp_mon.last);
                  error_total++;
               end
               void'(expected_results.pop_front());
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            apply_timer_request(req_mon.opcode, req_mon.now_ms, req_mon.timeout_ms,
                                req_mon.handle);
         end
      end
   end

endmodule

### verif/tb_timeout_priority_queue_top.sv
// testbench top of the timeout priority queue: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_timeout_priority_queue_top;
   import tpq_pkg::*;

   localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int ITEM_TARGET    = 270;
   localparam int QUIET_ITEMS    = 40;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 20;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_outstanding;
   int   sent_items = 0;
   int   idle_cycles = 0;
   int   stall_left = 0;
   bit   quiet = 1'b0;
   logic [TIME_BITS-1:0] timeline;

   tpq_req_if req_bus ();
   tpq_rsp_if rsp_bus ();

   timeout_priority_queue_top #(
      .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
      .HANDLE_BITS(HANDLE_BITS_DEF)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   tpq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
      .HANDLE_BITS(HANDLE_BITS_DEF)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .req_mon(req_bus),
      .rsp_mon(rsp_bus),
      .mismatch_count(mismatch_count),
      .results_outstanding(results_outstanding)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver with random stall bursts
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (quiet) begin
            rsp_bus.ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 15) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // mostly a few handles so that cancels find matches
   function automatic logic [IN_HANDLE_BITS-1:0] pick_handle();
      if ($urandom_range(0, 3) == 0) return IN_HANDLE_BITS'($urandom_range(0, 255));
      return IN_HANDLE_BITS'($urandom_range(0, 15));
   endfunction

   // one request transaction, with an occasional idle burst ahead of it
   task automatic send_req(logic [OPCODE_BITS-1:0] opcode, logic [TIME_BITS-1:0] now_ms,
                           logic [TIMEOUT_BITS-1:0] timeout_ms,
                           logic [IN_HANDLE_BITS-1:0] handle);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         @(negedge clock);
         req_bus.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.opcode     = opcode;
      req_bus.now_ms     = now_ms;
      req_bus.timeout_ms = timeout_ms;
      req_bus.handle     = handle;
      req_bus.valid      = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (opcode != OP_UNUSED) sent_items++;
   endtask

   // hold the sender until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (results_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // fill past capacity, then sweep more expired entries than one sweep reports
   task automatic run_fill();
      logic [TIME_BITS-1:0] base;
      base = TIME_BITS'($urandom_range(0, 32'h3FFF_FFFF));
      for (int i = 0; i < QUEUE_DEPTH_DEF + 4; i++) begin
         send_req(OP_ADD, base + TIME_BITS'(i), TIMEOUT_BITS'($urandom_range(0, 50)),
                  IN_HANDLE_BITS'($urandom_range(0, 255)));
      end
      send_req(OP_SWEEP, base + 32'd5000, '0, '0);
      send_req(OP_SWEEP, base + 32'd5000, '0, '0);
   endtask

   // mixed traffic on a running time line until the item count reaches upto
   task automatic run_mixed(int upto);
      int                        pick;
      logic [TIME_BITS-1:0]      now_ms;
      logic [TIMEOUT_BITS-1:0]   timeout_ms;
      while (sent_items < upto) begin
         timeline += TIME_BITS'($urandom_range(0, 400));
         if ($urandom_range(0, 20) == 0) timeline += 32'd3000;
         now_ms = ($urandom_range(0, 99) < 85) ? timeline : TIME_BITS'($urandom());
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            if ($urandom_range(0, 9) == 0)
               timeout_ms = TIMEOUT_BITS'($urandom_range(0, 20'hFFFFF));
            else
               timeout_ms = TIMEOUT_BITS'($urandom_range(0, 1500));
            send_req(OP_ADD, now_ms, timeout_ms, pick_handle());
         end else if (pick < 60) begin
            send_req(OP_CANCEL, TIME_BITS'($urandom()),
                     TIMEOUT_BITS'($urandom_range(0, 20'hFFFFF)), pick_handle());
         end else if (pick < 92) begin
            send_req(OP_SWEEP, now_ms, TIMEOUT_BITS'($urandom_range(0, 20'hFFFFF)),
                     IN_HANDLE_BITS'($urandom_range(0, 255)));
         end else begin
            send_req(OP_UNUSED, TIME_BITS'($urandom()),
                     TIMEOUT_BITS'($urandom_range(0, 20'hFFFFF)),
                     IN_HANDLE_BITS'($urandom_range(0, 255)));
         end
      end
   endtask

   // main sequence
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_ADD;
      req_bus.now_ms     = '0;
      req_bus.timeout_ms = '0;
      req_bus.handle     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty queue, saturation, equal expiry, cancel, unused opcode
      send_req(OP_SWEEP, '0, '0, '0);
      send_req(OP_CANCEL, '0, '0, 8'h55);
      send_req(OP_ADD, '0, '0, 8'h00);
      send_req(OP_ADD, TIME_MAX, 20'hFFFFF, 8'hFF);
      send_req(OP_ADD, 32'hFFFF_F000, 20'h01000, 8'hC3);
      send_req(OP_ADD, 32'hFFFF_F000, 20'h00FFF, 8'h3C);
      send_req(OP_ADD, 32'd1000, 20'd1000, 8'h12);
      send_req(OP_ADD, 32'd1000, 20'd1000, 8'h34);
      send_req(OP_ADD, 32'd500, 20'd1000, 8'h12);
      send_req(OP_CANCEL, 32'hFFFF_FFFF, 20'hFFFFF, 8'h12);
      send_req(OP_UNUSED, 32'h1234_5678, 20'h5A5A5, 8'hA5);
      send_req(OP_SWEEP, 32'd1999, '0, '0);
      send_req(OP_SWEEP, 32'd2000, '0, '0);
      send_req(OP_ADD, 32'hAAAA_AAAA, 20'h55555, 8'hAA);
      send_req(OP_ADD, 32'h5555_5555, 20'hAAAAA, 8'h55);
      send_req(OP_CANCEL, '0, '0, 8'hAA);
      send_req(OP_CANCEL, '0, '0, 8'h99);
      send_req(OP_SWEEP, 32'hFFFF_FFFE, '0, '0);
      send_req(OP_SWEEP, TIME_MAX, 20'hFFFFF, 8'hFF);
      send_req(OP_SWEEP, TIME_MAX, '0, '0);
      wait_drained();

      // full queue and a sweep that hits the close limit
      run_fill();
      wait_drained();

      // random traffic, the last part with no idling on either side
      timeline = TIME_BITS'($urandom());
      run_mixed(ITEM_TARGET - QUIET_ITEMS);
      wait_drained();
      quiet = 1'b1;
      run_mixed(ITEM_TARGET);

      // let everything come back
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (results_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
